### design/interval_record_bin_scatter_assert.svh
// Assertion macros used by the interval record bin scatter top level.
`ifndef INTERVAL_RECORD_BIN_SCATTER_ASSERT_SVH
`define INTERVAL_RECORD_BIN_SCATTER_ASSERT_SVH
// Asserts that a condition implies a consequence in the same cycle.
`define IRBS_ASSERT_IMPL(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("implication failed");
// Asserts that a condition implies a consequence in the next cycle.
`define IRBS_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("next-cycle implication failed");
`endif

### design/irbs_pkg.sv
// Package with the types and constants of the interval record bin scatter.
`default_nettype none
package irbs_pkg;
	localparam logic [1:0] CMD_WIN = 2'd0;
	localparam logic [1:0] CMD_SEC = 2'd1;
	localparam logic [1:0] CMD_REC = 2'd2;
	localparam logic [1:0] FMT_NONE = 2'd0;
	localparam logic [1:0] FMT_BED = 2'd1;
	localparam logic [1:0] FMT_VAR = 2'd2;
	localparam logic [1:0] FMT_FIX = 2'd3;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_COARSE = 2'd2;
	localparam logic [1:0] ST_SKIP = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_WRD,
		S_WDIV,
		S_EVAL,
		S_OUT,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		D_BS,
		D_BE,
		D_LBS,
		D_LBE
	} div_sel_t;
endpackage
`default_nettype wire

### design/interval_record_bin_scatter.sv
// Top level of the interval record bin scatter.
`default_nettype none
// The block takes an item only while it is idle and no result waits in its output register.
// Window and section commands and skipped records answer in the cycle after the item is
// taken. A data record first divides its start and end by bin_resolution on one shared
// restoring divider that yields one quotient bit per cycle; a fixedStep record first forms
// its start with a shift-add multiplier. Every window visited in the slice is then read,
// its start and end divided and the overlap evaluated; a window that yields a write also
// passes an output state, and the walk ends in a final state. A write is held back until
// the next write or the end of the walk is known, so that the last result carries tlast;
// a stalled output stops the walk until the waiting result is taken.
module interval_record_bin_scatter import irbs_pkg::*; #(
	parameter int MAX_WINDOWS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_wdata,
	input wire logic s_tvalid,
	output logic s_tready,
	// cmd[1:0], table_index[7:2], window_end[13:8], first_pos[45:14], second_pos[77:46],
	// out_base[109:78], record_format[111:110], step_len[143:112], rec_value[175:144]
	input wire logic [175:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// write_base[31:0], write_count[63:32], write_value[95:64], status[97:96],
	// past_slice[98], zero fill to 104
	output logic [103:0] m_tdata,
	output logic m_tlast
);
	localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

	logic [31:0] win_start_mem [MAX_WINDOWS];
	logic [31:0] win_end_mem [MAX_WINDOWS];
	logic [31:0] win_base_mem [MAX_WINDOWS];

	logic [31:0] res_q;
	state_t state_q, state_d;
	logic [5:0] slice_first_q, slice_end_q;
	logic [1:0] sec_format_q;
	logic [31:0] sec_chr_start_q, sec_step_q, sec_span_q;
	logic [15:0] record_counter_q;
	logic stopped_q;

	logic [31:0] val_q;
	logic [31:0] end_q, bs_q, be_q, lbs_q, lbe_q;
	logic [31:0] rd_end_q, rd_base_q;
	logic [6:0] idx_q;
	logic nmo_q, any_q;
	div_sel_t dsel_q;
	logic [5:0] cnt_q;
	logic [31:0] dq_q, dr_q, dd_q, prod_q, mc_q;
	logic [15:0] mp_q;
	logic [31:0] p_base_q, p_count_q;
	logic [31:0] o_base_q, o_count_q, o_value_q;
	logic [1:0] o_status_q;
	logic o_nmo_q, o_last_q, o_valid_q;

	logic [1:0] in_cmd, in_fmt;
	logic [5:0] in_tidx, in_wend;
	logic [31:0] in_p1, in_p2, in_obase, in_step, in_val;
	logic [31:0] res_eff;
	logic [6:0] lim;
	logic [32:0] rem_sh;
	logic [33:0] rem_sub;
	logic [31:0] os, oe;
	logic [31:0] mul_start;
	logic [1:0] sec_status, acc_status;
	logic accept;

	assign in_cmd = s_tdata[1:0];
	assign in_tidx = s_tdata[7:2];
	assign in_wend = s_tdata[13:8];
	assign in_p1 = s_tdata[45:14];
	assign in_p2 = s_tdata[77:46];
	assign in_obase = s_tdata[109:78];
	assign in_fmt = s_tdata[111:110];
	assign in_step = s_tdata[143:112];
	assign in_val = val_q;

	assign res_eff = (res_q == 32'd0) ? 32'd1 : res_q;
	assign lim = ({1'b0, slice_end_q} < 7'(MAX_WINDOWS)) ? {1'b0, slice_end_q}
		: 7'(MAX_WINDOWS);
	assign rem_sh = {dr_q, dd_q[31]};
	assign rem_sub = {1'b0, rem_sh} - {2'b0, res_eff};
	assign os = (bs_q > lbs_q) ? bs_q : lbs_q;
	assign oe = (be_q < lbe_q) ? be_q : lbe_q;
	assign mul_start = sec_chr_start_q + prod_q + (mp_q[0] ? mc_q : 32'd0);
	assign sec_status = (in_fmt == FMT_NONE) ? ST_INVALID
		: (in_fmt == FMT_FIX && res_eff > in_step) ? ST_COARSE : ST_OK;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		case (in_cmd)
			CMD_SEC: acc_status = sec_status;
			CMD_REC: acc_status = ST_SKIP;
			default: acc_status = ST_OK;
		endcase
	end

	assign s_tready = (state_q == S_IDLE) && !o_valid_q;
	assign m_tvalid = o_valid_q;
	assign m_tlast = o_last_q;
	assign m_tdata = {5'd0, o_nmo_q, o_status_q, o_value_q, o_count_q, o_base_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && in_cmd == CMD_REC && !stopped_q) begin
					state_d = (sec_format_q == FMT_FIX) ? S_MUL : S_DIV;
				end
			end
			S_MUL: begin
				if (cnt_q == 6'd15) state_d = S_DIV;
			end
			S_DIV: begin
				if (cnt_q == 6'd31 && dsel_q == D_BE) state_d = S_WRD;
			end
			S_WRD: begin
				if (idx_q >= lim) state_d = S_FIN;
				else state_d = S_WDIV;
			end
			S_WDIV: begin
				if (cnt_q == 6'd31 && dsel_q == D_LBE) state_d = S_EVAL;
			end
			S_EVAL: begin
				if (bs_q >= lbe_q) state_d = S_WRD;
				else if (be_q <= lbs_q) state_d = S_FIN;
				else if (oe > os) state_d = S_OUT;
				else state_d = S_WRD;
			end
			S_OUT: begin
				if (!o_valid_q) state_d = S_WRD;
			end
			S_FIN: begin
				if (!o_valid_q) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && in_cmd == CMD_WIN && {1'b0, in_tidx} < 7'(MAX_WINDOWS)) begin
			win_start_mem[in_tidx[IW-1:0]] <= in_p1;
			win_end_mem[in_tidx[IW-1:0]] <= in_p2;
			win_base_mem[in_tidx[IW-1:0]] <= in_obase;
		end
		rd_end_q <= win_end_mem[idx_q[IW-1:0]];
		rd_base_q <= win_base_mem[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= 32'd1;
			state_q <= S_IDLE;
			slice_first_q <= '0;
			slice_end_q <= '0;
			sec_format_q <= '0;
			sec_chr_start_q <= '0;
			sec_step_q <= '0;
			sec_span_q <= '0;
			record_counter_q <= '0;
			stopped_q <= 1'b1;
			o_valid_q <= 1'b0;
			cnt_q <= '0;
			dsel_q <= D_BS;
			idx_q <= '0;
			nmo_q <= 1'b1;
			any_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) res_q <= cfg_wdata;
			if (o_valid_q && m_tready) o_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q <= s_tdata[175:144];
						cnt_q <= '0;
						dsel_q <= D_BS;
						idx_q <= {1'b0, slice_first_q};
						nmo_q <= 1'b1;
						any_q <= 1'b0;
						o_base_q <= '0;
						o_count_q <= '0;
						o_value_q <= '0;
						o_nmo_q <= 1'b0;
						o_last_q <= 1'b1;
						o_status_q <= acc_status;
						case (in_cmd)
							CMD_WIN: o_valid_q <= 1'b1;
							CMD_SEC: begin
								o_valid_q <= 1'b1;
								slice_first_q <= in_tidx;
								slice_end_q <= in_wend;
								sec_format_q <= in_fmt;
								sec_chr_start_q <= in_p1;
								sec_span_q <= in_p2;
								sec_step_q <= in_step;
								record_counter_q <= '0;
								stopped_q <= (sec_status != ST_OK);
							end
							CMD_REC: begin
								if (stopped_q) begin
									o_valid_q <= 1'b1;
								end else begin
									dd_q <= in_p1;
									dr_q <= '0;
									if (sec_format_q == FMT_BED) end_q <= in_p2;
									else end_q <= in_p1 + sec_span_q;
									prod_q <= '0;
									mc_q <= sec_step_q;
									mp_q <= record_counter_q;
									if (sec_format_q == FMT_FIX)
										record_counter_q <= record_counter_q + 16'd1;
								end
							end
							default: ;
						endcase
					end
				end
				S_MUL: begin
					if (cnt_q == 6'd15) begin
						cnt_q <= '0;
						end_q <= mul_start + sec_span_q;
						dd_q <= mul_start;
						dr_q <= '0;
					end else begin
						if (mp_q[0]) prod_q <= prod_q + mc_q;
						mc_q <= {mc_q[30:0], 1'b0};
						mp_q <= {1'b0, mp_q[15:1]};
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_DIV, S_WDIV: begin
					if (cnt_q == 6'd31) begin
						cnt_q <= '0;
						dr_q <= '0;
						case (dsel_q)
							D_BS: begin
								bs_q <= {dd_q[30:0], ~rem_sub[33]};
								dsel_q <= D_BE;
								dd_q <= end_q;
							end
							D_BE: be_q <= {dd_q[30:0], ~rem_sub[33]};
							D_LBS: begin
								lbs_q <= {dd_q[30:0], ~rem_sub[33]};
								dsel_q <= D_LBE;
								dd_q <= rd_end_q;
							end
							default: lbe_q <= {dd_q[30:0], ~rem_sub[33]};
						endcase
					end else begin
						dd_q <= {dd_q[30:0], ~rem_sub[33]};
						dr_q <= rem_sub[33] ? rem_sh[31:0] : rem_sub[31:0];
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_WRD: begin
					dsel_q <= D_LBS;
					cnt_q <= '0;
					dr_q <= '0;
					dd_q <= win_start_mem[idx_q[IW-1:0]];
				end
				S_EVAL: begin
					if (state_d != S_OUT) idx_q <= idx_q + 7'd1;
					if (bs_q < lbe_q) nmo_q <= 1'b0;
				end
				S_OUT: begin
					if (!o_valid_q) begin
						if (any_q) begin
							o_valid_q <= 1'b1;
							o_base_q <= p_base_q;
							o_count_q <= p_count_q;
							o_value_q <= in_val;
							o_status_q <= ST_OK;
							o_nmo_q <= 1'b0;
							o_last_q <= 1'b0;
						end
						p_base_q <= rd_base_q + (os - lbs_q);
						p_count_q <= oe - os;
						any_q <= 1'b1;
						idx_q <= idx_q + 7'd1;
					end
				end
				S_FIN: begin
					if (!o_valid_q) begin
						if (nmo_q) stopped_q <= 1'b1;
						o_valid_q <= 1'b1;
						o_base_q <= any_q ? p_base_q : 32'd0;
						o_count_q <= any_q ? p_count_q : 32'd0;
						o_value_q <= any_q ? in_val : 32'd0;
						o_status_q <= ST_OK;
						o_nmo_q <= nmo_q && !any_q;
						o_last_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	`include "interval_record_bin_scatter_assert.svh"
	`IRBS_ASSERT_IMPL(a_no_accept_busy, state_q != S_IDLE, !s_tready)
	`IRBS_ASSERT_IMPL(a_write_nonzero, m_tvalid && !m_tlast, m_tdata[63:32] != 32'd0)
	`IRBS_ASSERT_NEXT(a_fin_to_idle, state_q == S_FIN && !o_valid_q, state_q == S_IDLE)
endmodule
`default_nettype wire
